>>> rtl/rpa_pkg.sv
// Package: AES-128 round helpers and constants for the private address matcher
`default_nettype none
package rpa_pkg;

  localparam int unsigned AddrWidth   = 48;
  localparam int unsigned HashWidth   = 24;
  localparam int unsigned KeyWidth    = 128;
  localparam int unsigned RegWidth    = 64;
  localparam int unsigned IndexWidth  = 8;
  localparam int unsigned Rounds      = 10;

  localparam logic [7:0] TypeMask = 8'hC0;
  localparam logic [7:0] TypeRpa  = 8'h40;

  localparam logic [IndexWidth-1:0] RegIrkLow  = 8'd0;
  localparam logic [IndexWidth-1:0] RegIrkHigh = 8'd1;

  localparam logic [7:0] Rcon [Rounds] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  typedef logic [KeyWidth-1:0] block_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte k of a block, byte 0 in the top bits
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned k);
    return b[KeyWidth-1-8*k -: 8];
  endfunction

  // One cipher round; the last round leaves out the column mix
  function automatic block_t aes_round(input block_t s, input block_t rk,
                                       input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    block_t     o;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = Sbox[get_byte(s, i + 4*((c + i) % 4))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        x  = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      o[KeyWidth-1-8*k -: 8] = t[k];
    end
    return o ^ rk;
  endfunction

  // Next round key from the previous one
  function automatic block_t key_step(input block_t rk, input logic [7:0] rc);
    logic [31:0] tw, w0, w1, w2, w3;
    tw = {Sbox[rk[23:16]] ^ rc, Sbox[rk[15:8]], Sbox[rk[7:0]], Sbox[rk[31:24]]};
    w0 = rk[127:96] ^ tw;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

>>> rtl/rpa_if.sv
// Interfaces: address requests, match results and register writes
`default_nettype none
interface rpa_addr_if;
  logic                            valid;
  logic                            ready;
  logic [rpa_pkg::AddrWidth-1:0]   device_address;
  modport source (output valid, output device_address, input ready);
  modport sink   (input valid, input device_address, output ready);
endinterface

interface rpa_result_if;
  logic valid;
  logic ready;
  logic is_resolvable;
  logic is_match;
  modport source (output valid, output is_resolvable, output is_match, input ready);
  modport sink   (input valid, input is_resolvable, input is_match, output ready);
endinterface

interface rpa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rpa_pkg::IndexWidth-1:0]   index;
  logic [rpa_pkg::RegWidth-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/rpa_resolve_match_core.sv
// Top level: pipelined resolvable private address matcher
//
//   channel   dir  payload
//   addr_ch   in   device_address[47:0]
//   result_ch out  is_resolvable, is_match
//   cfg_ch    in   index[7:0] (0 irk_low, 1 irk_high), data[63:0]
//
// Eleven register stages: key whitening, then one AES round per stage with
// its round key derived alongside. One request per cycle while the result
// side takes results; each stage holds while the next is full and stalled.
// Reset (synchronous, rst) empties every stage and clears the key. Register
// writes are always taken.
`default_nettype none
module rpa_resolve_match_core (
  input  wire logic    clk,
  input  wire logic    rst,
  rpa_addr_if.sink     addr_ch,
  rpa_result_if.source result_ch,
  rpa_cfg_if.sink      cfg_ch
);

  localparam int unsigned Last = rpa_pkg::Rounds;

  logic [rpa_pkg::RegWidth-1:0]  irk_low, irk_high;
  logic [Last:0]                 v;
  logic [Last:0]                 adv;
  rpa_pkg::block_t               st   [Last+1];
  rpa_pkg::block_t               rk   [Last+1];
  logic [rpa_pkg::HashWidth-1:0] hash [Last+1];
  logic [Last:0]                 res;
  logic [7:0]                    top;

  // Key registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      irk_low  <= '0;
      irk_high <= '0;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == rpa_pkg::RegIrkLow) irk_low <= cfg_ch.data;
      if (cfg_ch.index == rpa_pkg::RegIrkHigh) irk_high <= cfg_ch.data;
    end
  end

  // Stage may load when empty or when it passes its item on
  always_comb begin
    adv[Last] = !v[Last] || result_ch.ready;
    for (int k = Last - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end
  assign addr_ch.ready = adv[0];
  assign top = addr_ch.device_address[47:40];

  // Stage 0: whiten the block {104 zeros, prand} with the key
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv[0]) begin
      v[0] <= addr_ch.valid;
    end
    if (adv[0]) begin
      rk[0]   <= {irk_high, irk_low};
      st[0]   <= {104'd0, addr_ch.device_address[47:24]} ^ {irk_high, irk_low};
      hash[0] <= addr_ch.device_address[23:0];
      res[0]  <= (top & rpa_pkg::TypeMask) == rpa_pkg::TypeRpa;
    end
  end

  // Rounds: advance one stage per round
  for (genvar r = 1; r <= Last; r++) begin : g_round
    rpa_pkg::block_t rk_next;
    assign rk_next = rpa_pkg::key_step(rk[r-1], rpa_pkg::Rcon[r-1]);
    always_ff @(posedge clk) begin
      if (rst) begin
        v[r] <= 1'b0;
      end else if (adv[r]) begin
        v[r] <= v[r-1];
      end
      if (adv[r]) begin
        rk[r]   <= rk_next;
        st[r]   <= rpa_pkg::aes_round(st[r-1], rk_next, r == Last);
        hash[r] <= hash[r-1];
        res[r]  <= res[r-1];
      end
    end
  end

  // Result from the last stage
  assign result_ch.valid         = v[Last];
  assign result_ch.is_resolvable = res[Last];
  assign result_ch.is_match      = res[Last] && (st[Last][23:0] == hash[Last]);

`ifndef SYNTHESIS
  a_match_needs_rpa: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> (!result_ch.is_match || result_ch.is_resolvable))
    else $error("match flagged on a non-resolvable address");
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (v == '0))
    else $error("pipeline not empty after reset");
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (addr_ch.valid && addr_ch.ready) |=> v[0])
    else $error("accepted request not held in first stage");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (v[Last] && !result_ch.ready && v[Last-1]) |=> (v[Last] && v[Last-1]))
    else $error("stalled stages dropped a request");
`endif

endmodule
`default_nettype wire

>>> dv/rpa_match_checker.sv
// Checker: watches the matcher's channels, predicts each verdict and compares it
`timescale 1ns / 100ps
`default_nettype none
module rpa_match_checker (
  input  wire logic clk,
  input  wire logic rst,
  rpa_addr_if       addr_ch,
  rpa_result_if     result_ch,
  rpa_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct packed {
    logic is_resolvable;
    logic is_match;
  } verdict_t;

  logic [rpa_pkg::RegWidth-1:0] irk_lo_q;
  logic [rpa_pkg::RegWidth-1:0] irk_hi_q;
  verdict_t                     verdict_q[$];
  int                           result_no;

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Low 24 bits of AES-128 under irk of the block 104 zero bits then prand
  function automatic logic [rpa_pkg::HashWidth-1:0] rpa_ah(
      input logic [rpa_pkg::KeyWidth-1:0] irk,
      input logic [rpa_pkg::HashWidth-1:0] prand);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] w [4];
    logic [7:0] rc, f, a0, a1, a2, a3, x;
    for (int k = 0; k < 16; k++) rk[k] = irk[rpa_pkg::KeyWidth-1-8*k -: 8];
    rc = 8'h01;
    // expand the key schedule
    for (int i = 16; i < 176; i += 4) begin
      for (int c = 0; c < 4; c++) w[c] = rk[i-4+c];
      if (i % 16 == 0) begin
        f    = w[0];
        w[0] = rpa_pkg::Sbox[w[1]] ^ rc;
        w[1] = rpa_pkg::Sbox[w[2]];
        w[2] = rpa_pkg::Sbox[w[3]];
        w[3] = rpa_pkg::Sbox[f];
        rc   = gf_double(rc);
      end
      for (int c = 0; c < 4; c++) rk[i+c] = rk[i-16+c] ^ w[c];
    end
    // whiten the plaintext
    for (int k = 0; k < 16; k++) st[k] = rk[k];
    st[13] ^= prand[23:16];
    st[14] ^= prand[15:8];
    st[15] ^= prand[7:0];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) sh[i+4*c] = rpa_pkg::Sbox[st[i + 4*((c+i) % 4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
          x  = a0 ^ a1 ^ a2 ^ a3;
          sh[4*c]   = a0 ^ x ^ gf_double(a0 ^ a1);
          sh[4*c+1] = a1 ^ x ^ gf_double(a1 ^ a2);
          sh[4*c+2] = a2 ^ x ^ gf_double(a2 ^ a3);
          sh[4*c+3] = a3 ^ x ^ gf_double(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) st[k] = sh[k] ^ rk[16*r+k];
    end
    return {st[13], st[14], st[15]};
  endfunction

  task automatic report(input string what, input logic got, input logic want);
    $display("mismatch: result %0d %s got %0b want %0b", result_no, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    verdict_t v;
    logic [rpa_pkg::AddrWidth-1:0] a;
    if (rst) begin
      irk_lo_q <= '0;
      irk_hi_q <= '0;
      verdict_q.delete();
      result_no = 0;
      fail_count = 0;
    end else begin
      // track the key; other indexes are dropped
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == rpa_pkg::RegIrkLow) irk_lo_q <= cfg_ch.data;
        else if (cfg_ch.index == rpa_pkg::RegIrkHigh) irk_hi_q <= cfg_ch.data;
      end
      // check the oldest verdict
      if (result_ch.valid && result_ch.ready) begin
        if (verdict_q.size() == 0) begin
          $display("mismatch: result %0d arrived with no request outstanding", result_no);
          fail_count++;
        end else begin
          v = verdict_q.pop_front();
          if (result_ch.is_resolvable !== v.is_resolvable)
            report("is_resolvable", result_ch.is_resolvable, v.is_resolvable);
          if (result_ch.is_match !== v.is_match)
            report("is_match", result_ch.is_match, v.is_match);
        end
        result_no++;
      end
      // predict each accepted request
      if (addr_ch.valid && addr_ch.ready) begin
        a = addr_ch.device_address;
        v.is_resolvable = (a[47:40] & rpa_pkg::TypeMask) == rpa_pkg::TypeRpa;
        v.is_match = v.is_resolvable &&
                     (rpa_ah({irk_hi_q, irk_lo_q}, a[47:24]) == a[23:0]);
        verdict_q.push_back(v);
      end
    end
    pending = verdict_q.size();
  end
endmodule
`default_nettype wire

>>> dv/tb_rpa_resolve_match_core.sv
// Testbench top: stimulus, key phases and verdict for the private address matcher
`timescale 1ns / 100ps
`default_nettype none
module tb_rpa_resolve_match_core;

  localparam logic [rpa_pkg::IndexWidth-1:0] RegFirstUnused = 8'd2;
  localparam logic [rpa_pkg::IndexWidth-1:0] RegTopIndex    = 8'hFF;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 30;
  localparam int PhaseCount   = 5;
  localparam int RandPerPhase = 150;

  logic clk = 1'b0;
  logic rst;
  int   fail_count, pending;
  int   cycle_no = 0;
  logic long_hold;
  int   burst_left;
  logic [rpa_pkg::KeyWidth-1:0] irk;

  rpa_addr_if   addr_ch ();
  rpa_result_if result_ch ();
  rpa_cfg_if    cfg_ch ();

  rpa_resolve_match_core u_top (
    .clk(clk), .rst(rst), .addr_ch(addr_ch), .result_ch(result_ch), .cfg_ch(cfg_ch)
  );

  rpa_match_checker u_chk (
    .clk(clk), .rst(rst), .addr_ch(addr_ch), .result_ch(result_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [rpa_pkg::IndexWidth-1:0] idx,
                           input logic [rpa_pkg::RegWidth-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // offer one request in bursts, hold until taken
  task automatic send_addr(input logic [rpa_pkg::AddrWidth-1:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        addr_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    addr_ch.valid          <= 1'b1;
    addr_ch.device_address <= a;
    @(posedge clk);
    while (!addr_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic go_idle();
    addr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [rpa_pkg::AddrWidth-1:0] pick_address();
    logic [rpa_pkg::HashWidth-1:0] prand, ah;
    int r;
    r     = $urandom_range(0, 9);
    prand = {2'b01, 22'($urandom)};
    ah    = u_chk.rpa_ah(irk, prand);
    if (r < 4) return {prand, ah};
    if (r < 7) return {prand, ah ^ (24'd1 << $urandom_range(0, 23))};
    return {16'($urandom), 32'($urandom)};
  endfunction

  // receiver: stall patterns, plus one long hold-off on request
  initial begin
    int seg, mode;
    logic hold_done;
    hold_done = 1'b0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_done = 1'b1;
      end
      seg  = $urandom_range(10, 80);
      mode = $urandom_range(0, 2);
      repeat (seg) begin
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= 1'($urandom);
          default: result_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [rpa_pkg::AddrWidth-1:0] directed [$];
    logic [rpa_pkg::RegWidth-1:0]  hi, lo;
    long_hold = 1'b0;
    burst_left = 0;
    irk = '0;
    rst <= 1'b1;
    addr_ch.valid <= 1'b0;
    addr_ch.device_address <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: begin hi = '0; lo = '0; end
        1: begin hi = '1; lo = '1; end
        4: begin hi = {$urandom, $urandom}; lo = '0; end
        default: begin hi = {$urandom, $urandom}; lo = {$urandom, $urandom}; end
      endcase
      write_reg(rpa_pkg::RegIrkLow, lo);
      write_reg(rpa_pkg::RegIrkHigh, hi);
      // stray writes must leave the key alone
      write_reg(RegFirstUnused, {$urandom, $urandom});
      write_reg(RegTopIndex, {$urandom, $urandom});
      irk = {hi, lo};

      if (ph < 2) begin
        directed = '{48'h0, '1, 48'h4000_0000_0000, 48'h7FFF_FFFF_FFFF,
                     48'h3FFF_FFFF_FFFF, 48'h8000_0000_0000, 48'hC000_0000_0000,
                     48'hBFFF_FFFF_FFFF};
        directed.push_back({24'h400000, u_chk.rpa_ah(irk, 24'h400000)});
        directed.push_back({24'h7FFFFF, u_chk.rpa_ah(irk, 24'h7FFFFF)});
        directed.push_back({24'h7FFFFF, ~u_chk.rpa_ah(irk, 24'h7FFFFF)});
        foreach (directed[i]) send_addr(directed[i]);
      end

      for (int n = 0; n < RandPerPhase; n++) begin
        if (ph == 2 && n == 20) long_hold = 1'b1;
        send_addr(pick_address());
      end
      go_idle();
    end

    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
